// File: design/cfdc_pkg.sv
// Shared types, constants and the CRC-32K octet update for the COBS frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package cfdc_pkg;

   localparam int LEN_W = 12;
   localparam logic [LEN_W-1:0] MAX_ENCODED_LENGTH = 12'd2048;
   localparam logic [LEN_W-1:0] CRC_FIELD_OCTETS = 12'd5;
   localparam logic [31:0] CRC32K_POLY = 32'hEB31D82E;
   localparam logic [31:0] CRC32K_START = 32'hFFFFFFFF;
   localparam logic [31:0] CRC32K_GOOD = 32'h0843323B;
   localparam logic [7:0] COBS_MASK = 8'h55;
   localparam logic [7:0] COBS_FULL_CODE = 8'd255;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT = 3'd1;
   localparam logic [2:0] ST_BAD_DATA_CODE = 3'd2;
   localparam logic [2:0] ST_BAD_CRC_CODE = 3'd3;
   localparam logic [2:0] ST_CRC_MISMATCH = 3'd4;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [7:0] enc_octet;
      logic frame_start;
      logic [LEN_W-1:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_octet;
      logic is_status;
      logic [2:0] status_code;
      logic [LEN_W-1:0] decoded_count;
      logic last_of_run;
   } rsp_type;

   // one input's worth of results: first, and optionally a second
   typedef struct packed {
      logic two;
      rsp_type first;
      rsp_type second;
   } job_type;

   function automatic logic [31:0] crc_feed(input logic [31:0] crc_i, input logic [7:0] octet_i);
      logic [31:0] c;
      logic [7:0] o;
      logic mix;
      c = crc_i;
      o = octet_i;
      for (int k = 0; k < 8; k++) begin
         mix = o[0] ^ c[0];
         c = c >> 1;
         if (mix) begin
            c = c ^ CRC32K_POLY;
         end
         o = o >> 1;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: design/cfdc_front.sv
// Front end: per-octet COBS decode, CRC update and result classification.
`timescale 1ns / 1ps
`default_nettype none
module cfdc_front
   import cfdc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req_data,
   output logic         job_push,
   output job_type      job
);

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] code_ff, code_in;
   logic [31:0] crc_ff, crc_in;
   logic [2:0] err_ff, err_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [2:0] crcn_ff, crcn_in;

   always_comb begin
      logic [LEN_W-1:0] p, len, dlen, cnt;
      logic [7:0] rem, code, v;
      logic [31:0] crc;
      logic [2:0] err, crcn, q;
      logic [LEN_W:0] p_plus_v;
      logic [8:0] q_plus_v;
      logic bad;
      logic [1:0] n;
      rsp_type r0, r1;

      if (req_data.frame_start) begin
         p = '0;
         rem = '0;
         code = '0;
         crc = CRC32K_START;
         err = ST_OK;
         cnt = '0;
         crcn = '0;
      end else begin
         p = pos_ff;
         rem = rem_ff;
         code = code_ff;
         crc = crc_ff;
         err = err_ff;
         cnt = cnt_ff;
         crcn = crcn_ff;
      end
      len = (req_data.frame_length > MAX_ENCODED_LENGTH) ? MAX_ENCODED_LENGTH
                                                         : req_data.frame_length;
      dlen = len - CRC_FIELD_OCTETS;
      v = req_data.enc_octet ^ COBS_MASK;
      q = 3'(p - dlen);
      p_plus_v = {1'b0, p} + {5'b0, v};
      q_plus_v = {6'b0, q} + {1'b0, v};
      bad = 1'b0;
      n = 2'd0;
      r0 = '0;
      r1 = '0;

      if (p < len) begin
         if (len < CRC_FIELD_OCTETS) begin
            if (p + 1'b1 == len) begin
               if (err == ST_OK) err = ST_TOO_SHORT;
               r0.is_status = 1'b1;
               r0.status_code = err;
               r0.decoded_count = cnt;
               n = 2'd1;
            end
         end else if (p < dlen) begin
            crc = crc_feed(crc, req_data.enc_octet);
            if (err == ST_OK) begin
               if (rem == '0) begin
                  if (v == '0 || p_plus_v > {1'b0, dlen}) begin
                     err = ST_BAD_DATA_CODE;
                     bad = 1'b1;
                  end else begin
                     code = v;
                     rem = v - 1'b1;
                  end
               end else begin
                  r0.out_octet = v;
                  n = 2'd1;
                  cnt = cnt + 1'b1;
                  rem = rem - 1'b1;
               end
               if (!bad && rem == '0 && code != COBS_FULL_CODE && p + 1'b1 < dlen) begin
                  if (n == 2'd0) begin
                     r0.out_octet = '0;
                  end else begin
                     r1.out_octet = '0;
                  end
                  n = n + 1'b1;
                  cnt = cnt + 1'b1;
               end
            end
         end else begin
            if (q == '0) rem = '0;
            if (rem == '0) begin
               if (v == '0 || q_plus_v > 9'd5) begin
                  if (err == ST_OK) err = ST_BAD_CRC_CODE;
                  bad = 1'b1;
                  code = '0;
               end else begin
                  code = v;
                  rem = v - 1'b1;
               end
            end else begin
               crc = crc_feed(crc, v);
               if (crcn != 3'd7) crcn = crcn + 1'b1;
               rem = rem - 1'b1;
            end
            if (!bad && rem == '0 && code != COBS_FULL_CODE && q < 3'd4) begin
               crc = crc_feed(crc, 8'd0);
               if (crcn != 3'd7) crcn = crcn + 1'b1;
            end
            if (p + 1'b1 == len) begin
               if (err == ST_OK) begin
                  if (crcn != 3'd4) err = ST_BAD_CRC_CODE;
                  else if (crc != CRC32K_GOOD) err = ST_CRC_MISMATCH;
                  else if (cnt == '0) err = ST_TOO_SHORT;
               end
               r0.is_status = 1'b1;
               r0.status_code = err;
               r0.decoded_count = cnt;
               n = 2'd1;
            end
         end
         p = p + 1'b1;
      end

      if (n == 2'd2) r1.last_of_run = 1'b1;
      else r0.last_of_run = 1'b1;

      pos_in = p;
      rem_in = rem;
      code_in = code;
      crc_in = crc;
      err_in = err;
      cnt_in = cnt;
      crcn_in = crcn;
      job.two = (n == 2'd2);
      job.first = r0;
      job.second = r1;
      job_push = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rem_ff <= '0;
         code_ff <= '0;
         crc_ff <= CRC32K_START;
         err_ff <= ST_OK;
         cnt_ff <= '0;
         crcn_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
         code_ff <= code_in;
         crc_ff <= crc_in;
         err_ff <= err_in;
         cnt_ff <= cnt_in;
         crcn_ff <= crcn_in;
      end
   end

endmodule
`default_nettype wire

// File: design/cfdc_queue.sv
// Short job queue between front end and result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cfdc_queue
   import cfdc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_job,
   input  wire logic    rd_en,
   output job_type      rd_job,
   output logic         q_full,
   output logic         q_empty
);

   job_type mem [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0] count_ff, count_in;

   assign q_full = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign q_empty = (count_ff == '0);
   assign rd_job = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      else if (!wr_en && rd_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: design/cfdc_back.sv
// Back end: holds one job and hands out its one or two result items.
`timescale 1ns / 1ps
`default_nettype none
module cfdc_back
   import cfdc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire job_type q_job,
   output logic         q_pop,
   input  wire logic    pop,
   output logic         empty,
   output rsp_type      rsp_data
);

   job_type job_ff;
   logic valid_ff, valid_in;
   logic idx_ff, idx_in;
   logic taken, done;

   assign empty = !valid_ff;
   assign rsp_data = idx_ff ? job_ff.second : job_ff.first;
   assign taken = valid_ff && pop;
   assign done = taken && (idx_ff || !job_ff.two);
   assign q_pop = !q_empty && (!valid_ff || done);

   always_comb begin
      valid_in = valid_ff;
      idx_in = idx_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         idx_in = 1'b0;
      end else if (done) begin
         valid_in = 1'b0;
         idx_in = 1'b0;
      end else if (taken) begin
         idx_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// File: design/cobs_frame_decode_crc32k_core.sv
// Top level of the streaming COBS frame decoder with CRC-32K check.
// Takes one encoded octet per cycle; each octet produces zero, one or two result
// items (decoded data octets, restored zeros, or the end-of-frame status). The
// front end decodes and updates the CRC in the cycle an item is accepted, then
// posts its results as one job into a four-entry queue; the back end hands the
// results out one per cycle while pop is given. Each job passes through a queue
// entry and then the back-end job register. Input is taken every cycle while the
// queue has room, so sustained rate is one octet per cycle, bounded by how fast results
// are popped; the one-result-per-cycle output port falls behind when octets yield two results.
`timescale 1ns / 1ps
`default_nettype none
module cobs_frame_decode_crc32k_core
   import cfdc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic accept;
   logic job_push;
   job_type job_w, q_job;
   logic q_full, q_empty, q_pop;

   assign full = q_full;
   assign accept = push && !q_full;

   cfdc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .job_push (job_push),
      .job      (job_w)
   );

   cfdc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_job  (job_w),
      .rd_en   (q_pop),
      .rd_job  (q_job),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   cfdc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_job    (q_job),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_status_form: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.is_status) |-> (rsp_data.out_octet == 8'd0 && rsp_data.last_of_run))
      else $error("malformed status item");

   a_data_form: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.is_status) |->
         (rsp_data.status_code == ST_OK && rsp_data.decoded_count == '0))
      else $error("malformed data item");

   a_full_holds_job: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue full while back end idle");

endmodule
`default_nettype wire
